/* rtl/core/ebab_pkg.sv */
// Shared types, operation codes and flag positions for the BCD-capable ALU.
package ebab_pkg;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] first_value;
        logic [7:0] second_value;
        logic [7:0] status_in;
    } ebab_in_t;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] status_out;
    } ebab_out_t;

    localparam logic [3:0] OP_OR   = 4'd0;
    localparam logic [3:0] OP_AND  = 4'd1;
    localparam logic [3:0] OP_XOR  = 4'd2;
    localparam logic [3:0] OP_BIT  = 4'd3;
    localparam logic [3:0] OP_ADC  = 4'd4;
    localparam logic [3:0] OP_SBC  = 4'd5;
    localparam logic [3:0] OP_CMP  = 4'd6;
    localparam logic [3:0] OP_ASL  = 4'd7;
    localparam logic [3:0] OP_ROL  = 4'd8;
    localparam logic [3:0] OP_LSR  = 4'd9;
    localparam logic [3:0] OP_ROR  = 4'd10;
    localparam logic [3:0] OP_LOAD = 4'd11;

    localparam int FLAG_N = 7;
    localparam int FLAG_V = 6;
    localparam int FLAG_D = 3;
    localparam int FLAG_Z = 1;
    localparam int FLAG_C = 0;

    function automatic logic [7:0] set_nz(input logic [7:0] st, input logic [7:0] r);
        logic [7:0] s;
        s = st;
        s[FLAG_N] = r[7];
        s[FLAG_Z] = (r == 8'h00);
        return s;
    endfunction

endpackage

/* rtl/core/ebab_alu.sv */
// Combinational ALU datapath: logic ops, bit test, binary and decimal add/subtract, compare, shifts, rotates, load.
module ebab_alu (
    input  ebab_pkg::ebab_in_t  op_in,
    output ebab_pkg::ebab_out_t op_out
);
    import ebab_pkg::*;

    logic [7:0]        a;
    logic [7:0]        b;
    logic [7:0]        st;
    logic              cin;
    logic              borrow;
    logic [8:0]        bin_sum;
    logic [8:0]        bin_diff;
    logic [8:0]        cmp_diff;
    logic [4:0]        dadd_lo;
    logic [4:0]        dadd_hi;
    logic [4:0]        dadd_lo_fix;
    logic [5:0]        dadd_hi_fix;
    logic              dadd_c;
    logic signed [5:0] dsub_lo;
    logic signed [5:0] dsub_hi;
    logic signed [5:0] dsub_lo_fix;
    logic signed [5:0] dsub_hi_adj;
    logic signed [5:0] dsub_hi_fix;
    logic [7:0]        add_res;
    logic [7:0]        sub_res;
    logic              add_c;
    logic              sub_c;
    logic [7:0]        res;
    logic [7:0]        st_new;

    assign a      = op_in.first_value;
    assign b      = op_in.second_value;
    assign st     = op_in.status_in;
    assign cin    = st[FLAG_C];
    assign borrow = ~cin;

    assign bin_sum  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign bin_diff = {1'b0, a} - {1'b0, b} - {8'd0, borrow};
    assign cmp_diff = {1'b0, a} - {1'b0, b};

    always_comb begin
        dadd_lo     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        dadd_hi     = {1'b0, a[7:4]} + {1'b0, b[7:4]};
        dadd_lo_fix = dadd_lo;
        if (dadd_lo > 5'd9) begin
            dadd_lo_fix = dadd_lo + 5'd6;
            dadd_hi     = dadd_hi + 5'd1;
        end
        dadd_hi_fix = {1'b0, dadd_hi};
        dadd_c      = 1'b0;
        if (dadd_hi > 5'd9) begin
            dadd_hi_fix = {1'b0, dadd_hi} + 6'd6;
            dadd_c      = 1'b1;
        end

        dsub_lo     = $signed({2'b00, a[3:0]}) - $signed({2'b00, b[3:0]})
                      - $signed({5'd0, borrow});
        dsub_hi     = $signed({2'b00, a[7:4]}) - $signed({2'b00, b[7:4]});
        dsub_lo_fix = dsub_lo;
        dsub_hi_adj = dsub_hi;
        if (dsub_lo < 0) begin
            dsub_lo_fix = dsub_lo + 6'sd10;
            dsub_hi_adj = dsub_hi - 6'sd1;
        end
        dsub_hi_fix = dsub_hi_adj;
        if (dsub_hi_adj < 0) begin
            dsub_hi_fix = dsub_hi_adj + 6'sd10;
        end

        if (st[FLAG_D]) begin
            add_res = {dadd_hi_fix[3:0], dadd_lo_fix[3:0]};
            add_c   = dadd_c;
            sub_res = {dsub_hi_fix[3:0], dsub_lo_fix[3:0]};
            sub_c   = ~dsub_hi_adj[5];
        end else begin
            add_res = bin_sum[7:0];
            add_c   = bin_sum[8];
            sub_res = bin_diff[7:0];
            sub_c   = ~bin_diff[8];
        end
    end

    always_comb begin
        res    = a;
        st_new = st;
        unique case (op_in.op)
            OP_OR: begin
                res    = a | b;
                st_new = set_nz(st, res);
            end
            OP_AND: begin
                res    = a & b;
                st_new = set_nz(st, res);
            end
            OP_XOR: begin
                res    = a ^ b;
                st_new = set_nz(st, res);
            end
            OP_BIT: begin
                st_new[FLAG_Z] = ((a & b) == 8'h00);
                st_new[FLAG_N] = b[7];
                st_new[FLAG_V] = b[6];
            end
            OP_ADC: begin
                res            = add_res;
                st_new[FLAG_C] = add_c;
                st_new[FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ res[7]);
                st_new         = set_nz(st_new, res);
            end
            OP_SBC: begin
                res            = sub_res;
                st_new[FLAG_C] = sub_c;
                st_new[FLAG_V] = (a[7] ^ b[7]) & (a[7] ^ res[7]);
                st_new         = set_nz(st_new, res);
            end
            OP_CMP: begin
                st_new         = set_nz(st, cmp_diff[7:0]);
                st_new[FLAG_C] = ~cmp_diff[8];
            end
            OP_ASL, OP_ROL: begin
                res            = {a[6:0], (op_in.op == OP_ROL) ? cin : 1'b0};
                st_new[FLAG_C] = a[7];
                st_new         = set_nz(st_new, res);
            end
            OP_LSR, OP_ROR: begin
                res            = {(op_in.op == OP_ROR) ? cin : 1'b0, a[7:1]};
                st_new[FLAG_C] = a[0];
                st_new         = set_nz(st_new, res);
            end
            OP_LOAD: begin
                res    = b;
                st_new = set_nz(st, res);
            end
            default: begin
                res    = a;
                st_new = st;
            end
        endcase
    end

    assign op_out.result     = res;
    assign op_out.status_out = st_new;

endmodule

/* rtl/core/eight_bit_alu_with_bcd_core.sv */
// Top level: input register, ALU datapath and result register with handshakes.
// A beat accepted into in_reg passes the ALU into out_reg (m_data) once out_reg is free or draining.
// Throughput: one beat per cycle while m_ready is high; the input register refills while a result waits.
// Reset: synchronous, active low on aresetn; clears both valid flags only.
module eight_bit_alu_with_bcd_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ebab_pkg::ebab_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ebab_pkg::ebab_out_t m_data
);
    import ebab_pkg::*;

    ebab_in_t  in_reg;
    logic      in_valid_reg;
    logic      in_valid_next;
    ebab_out_t out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    ebab_out_t alu_out;
    logic      advance;

    ebab_alu u_alu (
        .op_in  (in_reg),
        .op_out (alu_out)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= alu_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
